// File: rtl/pcsb_pkg.sv
`timescale 1ns / 1ps

package pcsb_pkg;

	// Operation codes of the input word.
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_POINT = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_HEIGHT  = 3'd2;
	localparam logic [2:0] ST_NEAR    = 3'd3;
	localparam logic [2:0] ST_FAR     = 3'd4;
	localparam logic [2:0] ST_ANGLE   = 3'd5;
	localparam logic [2:0] ST_BIN     = 3'd6;

	// Configuration register indexes.
	localparam logic [2:0] CFG_HEIGHT_LOW  = 3'd0;
	localparam logic [2:0] CFG_HEIGHT_HIGH = 3'd1;
	localparam logic [2:0] CFG_RANGE_LOW   = 3'd2;
	localparam logic [2:0] CFG_RANGE_HIGH  = 3'd3;
	localparam logic [2:0] CFG_ANGLE_LOW   = 3'd4;
	localparam logic [2:0] CFG_ANGLE_HIGH  = 3'd5;
	localparam logic [2:0] CFG_ANGLE_STEP  = 3'd6;
	localparam logic [2:0] CFG_EMPTY_INF   = 3'd7;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 21;

	localparam logic [20:0] RANGE_INF = 21'h1FFFFF;
	localparam logic [20:0] RANGE_CAP = 21'd2097150;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [19:0] x_mm;
		logic signed [19:0] y_mm;
		logic signed [19:0] z_mm;
		logic               coords_valid;
		logic [8:0]         read_bin;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [8:0]  bin_index;
		logic [20:0] range_mm;
		logic [9:0]  ray_count;
	} rsp_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_RAYS, S_DISP, S_MY, S_MLO, S_MHI, S_MCMP, S_SQRT,
		S_RCHK, S_CORD, S_ACHK, S_IDIV, S_ICHK, S_UPD, S_RWAIT, S_WIPE, S_DONE
	} state_t;

	typedef enum logic [2:0] {
		MUL_NONE, MUL_X, MUL_Y, MUL_LO, MUL_HI, MUL_CMP
	} mul_op_t;

	typedef struct packed {
		logic       load;
		logic       rays_start;
		logic       rays_latch;
		logic       clear;
		mul_op_t    mul;
		logic       range_set;
		logic       cordic_init;
		logic       idx_start;
		logic       mem_rd_idx;
		logic       mem_rd_bin;
		logic       bin_rb;
		logic       upd;
		logic       read_set;
		logic       set_stat;
		logic [2:0] stat;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       cval;
		logic       height_bad;
		logic       rb_out;
		logic       near;
		logic       far;
		logic       sqrt_busy;
		logic       cordic_busy;
		logic       div_busy;
		logic       ang_out;
		logic       idx_out;
		logic       clr_last;
		logic       out_free;
	} sts_t;

	// Arctangent of 2^-i in units of 2^32 per turn.
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/pcsb_if.sv
`timescale 1ns / 1ps

// Input word channel.
interface pcsb_req_if
	import pcsb_pkg::*;
();
	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// Result word channel.
interface pcsb_rsp_if
	import pcsb_pkg::*;
();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/pcsb_ctrl.sv
`timescale 1ns / 1ps

module pcsb_ctrl
	import pcsb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT:  if (sts.clr_last) state_d = S_IDLE;
			S_IDLE:  if (req_valid) state_d = S_RAYS;
			S_RAYS:  if (!sts.div_busy) state_d = S_DISP;
			S_DISP: begin
				unique case (sts.op)
					OP_START: state_d = S_WIPE;
					OP_POINT: begin
						if (!sts.cval || sts.height_bad) state_d = S_DONE;
						else state_d = S_MY;
					end
					OP_READ: begin
						if (sts.rb_out) state_d = S_DONE;
						else state_d = S_RWAIT;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_MY:    state_d = S_MLO;
			S_MLO:   state_d = S_MHI;
			S_MHI:   state_d = S_MCMP;
			S_MCMP:  state_d = S_SQRT;
			S_SQRT:  if (!sts.sqrt_busy) state_d = S_RCHK;
			S_RCHK: begin
				if (sts.near || sts.far) state_d = S_DONE;
				else state_d = S_CORD;
			end
			S_CORD:  if (!sts.cordic_busy) state_d = S_ACHK;
			S_ACHK: begin
				if (sts.ang_out) state_d = S_DONE;
				else state_d = S_IDIV;
			end
			S_IDIV:  if (!sts.div_busy) state_d = S_ICHK;
			S_ICHK: begin
				if (sts.idx_out) state_d = S_DONE;
				else state_d = S_UPD;
			end
			S_UPD:   state_d = S_DONE;
			S_RWAIT: state_d = S_DONE;
			S_WIPE:  if (sts.clr_last) state_d = S_DONE;
			S_DONE:  if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_INIT;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		cmd.mul = MUL_NONE;
		unique case (state_q)
			S_INIT: cmd.clear = 1'b1;
			S_IDLE: begin
				cmd.load       = req_valid;
				cmd.rays_start = req_valid;
			end
			S_RAYS: cmd.rays_latch = !sts.div_busy;
			S_DISP: begin
				unique case (sts.op)
					OP_START: ;
					OP_POINT: begin
						if (!sts.cval) begin
							cmd.set_stat = 1'b1;
							cmd.stat     = ST_INVALID;
						end else if (sts.height_bad) begin
							cmd.set_stat = 1'b1;
							cmd.stat     = ST_HEIGHT;
						end else begin
							cmd.mul = MUL_X;
						end
					end
					OP_READ: begin
						cmd.bin_rb = 1'b1;
						if (sts.rb_out) begin
							cmd.set_stat = 1'b1;
							cmd.stat     = ST_BIN;
						end else begin
							cmd.mem_rd_bin = 1'b1;
						end
					end
					default: ;
				endcase
			end
			S_MY:   cmd.mul = MUL_Y;
			S_MLO:  cmd.mul = MUL_LO;
			S_MHI:  cmd.mul = MUL_HI;
			S_MCMP: cmd.mul = MUL_CMP;
			S_SQRT: ;
			S_RCHK: begin
				cmd.range_set = 1'b1;
				if (sts.near) begin
					cmd.set_stat = 1'b1;
					cmd.stat     = ST_NEAR;
				end else if (sts.far) begin
					cmd.set_stat = 1'b1;
					cmd.stat     = ST_FAR;
				end else begin
					cmd.cordic_init = 1'b1;
				end
			end
			S_CORD: ;
			S_ACHK: begin
				if (sts.ang_out) begin
					cmd.set_stat = 1'b1;
					cmd.stat     = ST_ANGLE;
				end else begin
					cmd.idx_start = 1'b1;
				end
			end
			S_IDIV: ;
			S_ICHK: begin
				if (sts.idx_out) begin
					cmd.set_stat = 1'b1;
					cmd.stat     = ST_BIN;
				end else begin
					cmd.mem_rd_idx = 1'b1;
				end
			end
			S_UPD:   cmd.upd = 1'b1;
			S_RWAIT: cmd.read_set = 1'b1;
			S_WIPE:  cmd.clear = 1'b1;
			S_DONE:  cmd.finish = sts.out_free;
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result register overwritten");

	// The shared divider only runs for the ray count and the bin index.
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> (state_q == S_RAYS || state_q == S_IDIV))
		else $error("divider busy outside its states");

	// The square root starts only out of the last multiplier step.
	a_sqrt_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sts.sqrt_busy) |-> state_q == S_SQRT && $past(state_q) == S_MCMP)
		else $error("square root started out of order");
`endif

endmodule

// File: rtl/pcsb_dp.sv
`timescale 1ns / 1ps

module pcsb_dp
	import pcsb_pkg::*;
#(
	parameter int NUM_BINS         = 512,
	parameter int EMPTY_EPSILON_MM = 1000,
	parameter int CORDIC_STEPS     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [CFG_IW-1:0] reg_index,
	input  logic [CFG_DW-1:0] wr_data,
	input  req_t              req_data,
	input  cmd_t              cmd,
	output sts_t              sts,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp_data
);

	localparam int BIN_W  = $clog2(NUM_BINS);
	localparam int RAY_W  = $clog2(NUM_BINS + 1);
	localparam int STEP_W = $clog2(CORDIC_STEPS + 1);
	localparam logic [RAY_W-1:0] RAY_MAX   = RAY_W'(NUM_BINS);
	localparam logic [16:0]      RAY_MAX17 = 17'(NUM_BINS);
	localparam logic [BIN_W-1:0] BIN_LAST  = BIN_W'(NUM_BINS - 1);
	localparam logic [21:0]      EPS22     = 22'(EMPTY_EPSILON_MM);
	localparam logic [STEP_W-1:0] STEPS    = STEP_W'(CORDIC_STEPS);
	localparam logic signed [33:0] ACC_HALF = 34'sd2147483648;
	localparam logic signed [16:0] ANG_MIN  = -17'sd32768;
	localparam logic signed [16:0] ANG_MAX  = 17'sd32768;

	// Configuration registers.
	logic signed [19:0] hlo_q, hhi_q;
	logic [20:0]        rlo_q, rhi_q;
	logic signed [15:0] alo_q, ahi_q;
	logic [15:0]        astep_q;
	logic               einf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hlo_q   <= '0;
			hhi_q   <= 20'sd524287;
			rlo_q   <= '0;
			rhi_q   <= RANGE_CAP;
			alo_q   <= 16'sh8000;
			ahi_q   <= 16'sd32767;
			astep_q <= 16'd182;
			einf_q  <= 1'b1;
		end else if (wr_en) begin
			unique case (reg_index)
				CFG_HEIGHT_LOW:  hlo_q   <= wr_data[19:0];
				CFG_HEIGHT_HIGH: hhi_q   <= wr_data[19:0];
				CFG_RANGE_LOW:   rlo_q   <= wr_data;
				CFG_RANGE_HIGH:  rhi_q   <= wr_data;
				CFG_ANGLE_LOW:   alo_q   <= wr_data[15:0];
				CFG_ANGLE_HIGH:  ahi_q   <= wr_data[15:0];
				CFG_ANGLE_STEP:  astep_q <= wr_data[15:0];
				CFG_EMPTY_INF:   einf_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Captured input word.
	logic [1:0]         op_q;
	logic signed [19:0] x_q, y_q, z_q;
	logic               cval_q;
	logic [8:0]         rb_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req_data.operation;
			x_q    <= req_data.x_mm;
			y_q    <= req_data.y_mm;
			z_q    <= req_data.z_mm;
			cval_q <= req_data.coords_valid;
			rb_q   <= req_data.read_bin;
		end
	end

	// Magnitudes and shared squaring multiplier.
	logic signed [20:0] xe, ye;
	logic [20:0]        ax, ay, mul_a;
	logic [41:0]        prod_q;
	logic [39:0]        r2_q;
	logic               near_q, far_q;

	assign xe = {x_q[19], x_q};
	assign ye = {y_q[19], y_q};
	assign ax = xe[20] ? 21'(-xe) : 21'(xe);
	assign ay = ye[20] ? 21'(-ye) : 21'(ye);

	always_comb begin
		case (cmd.mul)
			MUL_X:   mul_a = ax;
			MUL_Y:   mul_a = ay;
			MUL_LO:  mul_a = rlo_q;
			MUL_HI:  mul_a = rhi_q;
			default: mul_a = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_a;
		case (cmd.mul)
			MUL_Y:   r2_q   <= prod_q[39:0];
			MUL_LO:  r2_q   <= r2_q + prod_q[39:0];
			MUL_HI:  near_q <= {2'b00, r2_q} < prod_q;
			MUL_CMP: far_q  <= {2'b00, r2_q} > prod_q;
			default: ;
		endcase
	end

	// Bit-pair square root, one result bit per cycle.
	logic [41:0] rem_q, root_q, bit_q, trial;
	logic [20:0] rng_round;

	assign trial = root_q + bit_q;
	assign rng_round = root_q[20:0] + 21'(rem_q > root_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
		end else if (cmd.mul == MUL_CMP) begin
			bit_q <= 42'd1 << 40;
		end else if (bit_q != '0) begin
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul == MUL_CMP) begin
			rem_q  <= {2'b00, r2_q};
			root_q <= '0;
		end else if (bit_q != '0) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
		end
	end

	// CORDIC vectoring, one rotation per cycle.
	logic signed [39:0] cx_q, cy_q, dx, dy, xw, yw;
	logic signed [33:0] acc_q, at_s;
	logic [STEP_W-1:0]  cc_q, ci_q;
	logic               zero_q;

	assign xw   = {{4{x_q[19]}}, x_q, 16'h0000};
	assign yw   = {{4{y_q[19]}}, y_q, 16'h0000};
	assign dx   = cy_q >>> ci_q;
	assign dy   = cx_q >>> ci_q;
	assign at_s = {2'b00, atan_turn(5'(ci_q))};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q <= '0;
		end else if (cmd.cordic_init) begin
			cc_q <= STEPS;
		end else if (cc_q != '0) begin
			cc_q <= cc_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			zero_q <= (x_q == '0) && (y_q == '0);
			ci_q   <= '0;
			if (x_q[19]) begin
				cx_q  <= -xw;
				cy_q  <= -yw;
				acc_q <= y_q[19] ? -ACC_HALF : ACC_HALF;
			end else begin
				cx_q  <= xw;
				cy_q  <= yw;
				acc_q <= '0;
			end
		end else if (cc_q != '0) begin
			ci_q <= ci_q + 1'b1;
			if (!cy_q[39]) begin
				cx_q  <= cx_q + dx;
				cy_q  <= cy_q - dy;
				acc_q <= acc_q + at_s;
			end else begin
				cx_q  <= cx_q - dx;
				cy_q  <= cy_q + dy;
				acc_q <= acc_q - at_s;
			end
		end
	end

	// Binary angle: round, clamp and window test.
	logic signed [33:0] accr;
	logic signed [17:0] qv;
	logic signed [16:0] ang, alo17, ahi17, span;

	assign accr  = acc_q + 34'sd32768;
	assign qv    = accr[33:16];
	assign alo17 = {alo_q[15], alo_q};
	assign ahi17 = {ahi_q[15], ahi_q};
	assign span  = ahi17 - alo17;

	always_comb begin
		if (zero_q) ang = '0;
		else if (qv < 18'(ANG_MIN)) ang = ANG_MIN;
		else if (qv > 18'(ANG_MAX)) ang = ANG_MAX;
		else ang = qv[16:0];
	end

	// Shared restoring divider for ray count and bin index.
	logic [15:0] stp, dr_q, dd_q;
	logic [16:0] dq_q, dtmp, dvd;
	logic [4:0]  dn_q;
	logic        rneg_q;
	logic        dstart;

	assign stp    = (astep_q == '0) ? 16'd1 : astep_q;
	assign dstart = cmd.rays_start || cmd.idx_start;
	assign dvd    = cmd.rays_start ? (17'(span) + 17'(stp) - 17'd1) : 17'(ang - alo17);
	assign dtmp   = {dr_q, dq_q[16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dn_q <= '0;
		end else if (dstart) begin
			dn_q <= 5'd17;
		end else if (dn_q != '0) begin
			dn_q <= dn_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rays_start) rneg_q <= span[16];
		if (dstart) begin
			dq_q <= dvd;
			dr_q <= '0;
			dd_q <= stp;
		end else if (dn_q != '0) begin
			if (dtmp >= {1'b0, dd_q}) begin
				dr_q <= 16'(dtmp - {1'b0, dd_q});
				dq_q <= {dq_q[15:0], 1'b1};
			end else begin
				dr_q <= dtmp[15:0];
				dq_q <= {dq_q[15:0], 1'b0};
			end
		end
	end

	// Rays in use for the current word.
	logic [RAY_W-1:0] rays_q;
	logic [16:0]      rays17;
	logic [9:0]       ray_cnt;

	always_ff @(posedge clk) begin
		if (cmd.rays_latch) begin
			if (rneg_q) rays_q <= '0;
			else if (dq_q > RAY_MAX17) rays_q <= RAY_MAX;
			else rays_q <= RAY_W'(dq_q);
		end
	end

	assign rays17  = 17'(rays_q);
	assign ray_cnt = (rays17 > 17'd1023) ? 10'd1023 : rays17[9:0];

	// Result fields under construction.
	logic [2:0]  stat_q;
	logic [8:0]  bin_q;
	logic [20:0] range_q;
	logic [21:0] fill_sum;
	logic [20:0] empty_val;

	// Bin memory: filled flag over range.
	logic [21:0]      mem_q [NUM_BINS];
	logic [21:0]      rd_q;
	logic [BIN_W-1:0] clr_q, rd_addr, wr_addr;
	logic [21:0]      wd;
	logic             we, upd_wr;

	assign upd_wr  = cmd.upd && (!rd_q[21] || range_q < rd_q[20:0]);
	assign we      = cmd.clear || upd_wr;
	assign wr_addr = cmd.clear ? clr_q : dq_q[BIN_W-1:0];
	assign wd      = cmd.clear ? 22'd0 : {1'b1, range_q};
	assign rd_addr = cmd.mem_rd_bin ? BIN_W'(rb_q) : dq_q[BIN_W-1:0];

	always_ff @(posedge clk) begin
		if (we) mem_q[wr_addr] <= wd;
		if (cmd.mem_rd_bin || cmd.mem_rd_idx) rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= (clr_q == BIN_LAST) ? '0 : clr_q + 1'b1;
		end
	end

	// Empty bin fill value and result field updates.
	assign fill_sum  = {1'b0, rhi_q} + EPS22;
	assign empty_val = einf_q ? RANGE_INF :
		((fill_sum > {1'b0, RANGE_CAP}) ? RANGE_CAP : fill_sum[20:0]);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			stat_q  <= ST_OK;
			bin_q   <= '0;
			range_q <= '0;
		end else begin
			if (cmd.set_stat) stat_q <= cmd.stat;
			if (cmd.bin_rb) bin_q <= rb_q;
			if (cmd.upd) bin_q <= dq_q[8:0];
			if (cmd.range_set) range_q <= rng_round;
			if (cmd.read_set) range_q <= rd_q[21] ? rd_q[20:0] : empty_val;
		end
	end

	// Output register.
	logic out_v_q;
	rsp_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.finish) begin
			out_v_q <= 1'b1;
		end else if (rsp_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q <= '{status: stat_q, bin_index: bin_q, range_mm: range_q,
				ray_count: ray_cnt};
		end
	end

	assign rsp_valid = out_v_q;
	assign rsp_data  = res_q;

	// Status to the controller.
	always_comb begin
		sts.op          = op_q;
		sts.cval        = cval_q;
		sts.height_bad  = (z_q > hhi_q) || (z_q < hlo_q);
		sts.rb_out      = {8'b0, rb_q} >= rays17;
		sts.near        = near_q;
		sts.far         = far_q;
		sts.sqrt_busy   = bit_q != '0;
		sts.cordic_busy = cc_q != '0;
		sts.div_busy    = dn_q != '0;
		sts.ang_out     = (ang < alo17) || (ang > ahi17);
		sts.idx_out     = dq_q >= rays17;
		sts.clr_last    = clr_q == BIN_LAST;
		sts.out_free    = !out_v_q || rsp_ready;
	end

endmodule

// File: rtl/pointcloud_to_scan_binner.sv
`timescale 1ns / 1ps

// Point cloud to planar scan binner.
// Words enter on req (operation, x/y/z in mm, coords_valid, read_bin) and one
// result word per input leaves on rsp (status, bin_index, range_mm, ray_count).
// Configuration registers are written through wr_en, reg_index and wr_data;
// the user must write them only while no word is in flight; the block does not enforce this.
// One word is worked on at a time. Every word first runs the shared divider
// for the ray count. A point that reaches its bin passes through the
// squaring multiplier steps, 21 square root steps, CORDIC_STEPS rotations
// and the bin division. A start word sweeps the bin memory, one entry per
// cycle on its single write port.
// After reset the same sweep runs before req is ready.
// The result waits in an output register; the next word is taken while it
// waits, and only the finish of that next word stalls on a busy receiver.
module pointcloud_to_scan_binner
	import pcsb_pkg::*;
#(
	parameter int NUM_BINS         = 512,
	parameter int EMPTY_EPSILON_MM = 1000,
	parameter int CORDIC_STEPS     = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	pcsb_req_if.sink          req,
	pcsb_rsp_if.source        rsp,
	input  logic              wr_en,
	input  logic [CFG_IW-1:0] reg_index,
	input  logic [CFG_DW-1:0] wr_data
);

	cmd_t cmd;
	sts_t sts;

	pcsb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pcsb_dp #(
		.NUM_BINS         (NUM_BINS),
		.EMPTY_EPSILON_MM (EMPTY_EPSILON_MM),
		.CORDIC_STEPS     (CORDIC_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.reg_index (reg_index),
		.wr_data   (wr_data),
		.req_data  (req.data),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_data  (rsp.data)
	);

endmodule
